@@ design/crsc_pkg.sv @@
package crsc_pkg;

    localparam int ROWS_DEF    = 64;
    localparam int COLUMNS_DEF = 2048;

    localparam int COL_W   = 11;
    localparam int ROW_W   = 6;
    localparam int RANGE_W = 10;
    localparam int CNT_W   = 7;
    localparam int VR_W    = 7;
    localparam int SROW_W  = 12;

    localparam int QUEUE_DEPTH = 4;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 32;

    localparam logic [VR_W-1:0] VIEW_ROWS_RESET = 7'd64;

    typedef logic signed [SROW_W-1:0] srow_t;
    typedef logic [ROW_W-1:0]         row_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [COL_W-1:0]         col_t;

    // an absent range: top below every row, bottom above row zero
    localparam srow_t OFF_TOP   = 12'sd1024;
    localparam srow_t NO_BOTTOM = -12'sd1;

    localparam cnt_t CNT_ONE = 7'd1;

    // one column's work: four row runs, each given by its first row and length
    typedef struct packed {
        col_t col;
        col_t final_col;
        row_t ct_first;
        cnt_t ct_cnt;
        row_t cb_first;
        cnt_t cb_cnt;
        row_t ot_first;
        cnt_t ot_cnt;
        row_t ob_first;
        cnt_t ob_cnt;
    } span_cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CLOSE_TOP,
        BK_CLOSE_BOT,
        BK_OPEN_TOP,
        BK_OPEN_BOT
    } back_state_t;

endpackage

@@ design/crsc_front.sv @@
module crsc_front
    import crsc_pkg::*;
#(
    parameter int ROWS    = ROWS_DEF,
    parameter int COLUMNS = COLUMNS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [VR_W-1:0]      view_rows,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output span_cmd_t            cmd
);

    localparam logic [VR_W-1:0] ROWS_V   = VR_W'(ROWS);
    localparam col_t            COL_WRAP = COL_W'(COLUMNS - 1);

    col_t               in_col;
    logic               in_prev_valid;
    logic [RANGE_W-1:0] in_prev_top;
    logic [RANGE_W-1:0] in_prev_bottom;
    logic               in_cur_valid;
    logic [RANGE_W-1:0] in_cur_top;
    logic [RANGE_W-1:0] in_cur_bottom;

    logic [VR_W-1:0] eff_rows;
    srow_t           vr_m1;
    srow_t           pb;
    srow_t           cb;
    srow_t           t1_in;
    srow_t           b1_in;
    srow_t           t2_in;
    srow_t           b2_in;
    srow_t           b1p1;
    srow_t           lim1;
    logic            accept;

    logic  s1_valid_reg;
    srow_t t1a_reg;
    srow_t b1_reg;
    srow_t t2_reg;
    srow_t b2_reg;
    row_t  ct_first_reg;
    cnt_t  ct_cnt_reg;
    col_t  col_reg;
    col_t  final_reg;

    srow_t t1a_m1;
    srow_t b2p1;
    srow_t lim2;
    srow_t lim3;
    srow_t b1a;
    srow_t t2a;
    srow_t t2a_m1;
    srow_t lim4;
    srow_t cb_diff;
    srow_t ot_diff;
    srow_t ob_diff;

    assign in_col         = s_axis_tdata[10:0];
    assign in_prev_valid  = s_axis_tdata[11];
    assign in_prev_top    = s_axis_tdata[21:12];
    assign in_prev_bottom = s_axis_tdata[31:22];
    assign in_cur_valid   = s_axis_tdata[32];
    assign in_cur_top     = s_axis_tdata[42:33];
    assign in_cur_bottom  = s_axis_tdata[52:43];

    assign s_axis_tready = !s1_valid_reg || cmd_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // stage 1: clamp bottoms, close the top rows
    always_comb
    begin
        if (view_rows == '0)
        begin
            eff_rows = VR_W'(1);
        end
        else if (view_rows > ROWS_V)
        begin
            eff_rows = ROWS_V;
        end
        else
        begin
            eff_rows = view_rows;
        end
        vr_m1 = srow_t'({5'b0, eff_rows - VR_W'(1)});

        pb = srow_t'({2'b0, in_prev_bottom});
        cb = srow_t'({2'b0, in_cur_bottom});

        t1_in = in_prev_valid ? srow_t'({2'b0, in_prev_top}) : OFF_TOP;
        b1_in = in_prev_valid ? ((pb > vr_m1) ? vr_m1 : pb) : NO_BOTTOM;
        t2_in = in_cur_valid  ? srow_t'({2'b0, in_cur_top})  : OFF_TOP;
        b2_in = in_cur_valid  ? ((cb > vr_m1) ? vr_m1 : cb) : NO_BOTTOM;

        b1p1 = b1_in + srow_t'(1);
        lim1 = (b1p1 < t2_in) ? b1p1 : t2_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            t1a_reg      <= (t1_in < lim1) ? lim1 : t1_in;
            ct_cnt_reg   <= (t1_in < lim1) ? cnt_t'(lim1 - t1_in) : '0;
            ct_first_reg <= t1_in[ROW_W-1:0];
            b1_reg       <= b1_in;
            t2_reg       <= t2_in;
            b2_reg       <= b2_in;
            col_reg      <= in_col;
            final_reg    <= (in_col == '0) ? COL_WRAP : in_col - COL_W'(1);
        end
    end

    // stage 2: close bottoms, then the rows to open
    always_comb
    begin
        t1a_m1 = t1a_reg - srow_t'(1);
        b2p1   = b2_reg + srow_t'(1);
        lim2   = (t1a_m1 > b2_reg) ? t1a_m1 : b2_reg;
        lim3   = (b2p1 < t1a_reg) ? b2p1 : t1a_reg;
        b1a    = (b1_reg > lim2) ? lim2 : b1_reg;
        t2a    = (t2_reg < lim3) ? lim3 : t2_reg;
        t2a_m1 = t2a - srow_t'(1);
        lim4   = (t2a_m1 > b1a) ? t2a_m1 : b1a;
        if (lim4 < NO_BOTTOM)
        begin
            lim4 = NO_BOTTOM;
        end
        cb_diff = b1_reg - lim2;
        ot_diff = lim3 - t2_reg;
        ob_diff = b2_reg - lim4;

        cmd.col       = col_reg;
        cmd.final_col = final_reg;
        cmd.ct_first  = ct_first_reg;
        cmd.ct_cnt    = ct_cnt_reg;
        cmd.cb_first  = b1_reg[ROW_W-1:0];
        cmd.cb_cnt    = (b1_reg > lim2) ? cb_diff[CNT_W-1:0] : '0;
        cmd.ot_first  = t2_reg[ROW_W-1:0];
        cmd.ot_cnt    = (t2_reg < lim3) ? ot_diff[CNT_W-1:0] : '0;
        cmd.ob_first  = b2_reg[ROW_W-1:0];
        cmd.ob_cnt    = (b2_reg > lim4) ? ob_diff[CNT_W-1:0] : '0;
    end

    assign cmd_valid = s1_valid_reg;

endmodule

@@ design/crsc_fifo.sv @@
module crsc_fifo
    import crsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  span_cmd_t push_data,
    output logic      head_valid,
    input  logic      pop,
    output span_cmd_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    span_cmd_t          slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg != (PTR_W + 1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;
    assign head       = slot[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (PTR_W + 1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (PTR_W + 1)'(1);
            end
        end
    end

endmodule

@@ design/crsc_back.sv @@
module crsc_back
    import crsc_pkg::*;
#(
    parameter int ROWS = ROWS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  span_cmd_t             head,
    output logic                  pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PAD_W = OUT_DATA_W - 2 * COL_W - ROW_W;

    function automatic back_state_t next_phase(back_state_t cur, span_cmd_t c);
        logic        after_ct;
        logic        after_cb;
        logic        after_ot;
        logic        after_ob;
        back_state_t res;
        after_ct = (cur == BK_IDLE);
        after_cb = after_ct || (cur == BK_CLOSE_TOP);
        after_ot = after_cb || (cur == BK_CLOSE_BOT);
        after_ob = after_ot || (cur == BK_OPEN_TOP);
        if (after_ct && c.ct_cnt != '0)
        begin
            res = BK_CLOSE_TOP;
        end
        else if (after_cb && c.cb_cnt != '0)
        begin
            res = BK_CLOSE_BOT;
        end
        else if (after_ot && c.ot_cnt != '0)
        begin
            res = BK_OPEN_TOP;
        end
        else if (after_ob && c.ob_cnt != '0)
        begin
            res = BK_OPEN_BOT;
        end
        else
        begin
            res = BK_IDLE;
        end
        return res;
    endfunction

    col_t mem [ROWS];

    back_state_t state_reg;
    back_state_t state_next;
    back_state_t phase_after;
    row_t        row_reg;
    row_t        row_next;
    cnt_t        cnt_reg;
    cnt_t        cnt_next;

    logic issue_ok;
    logic issue;
    logic wr_en;
    logic step;
    logic advance;
    logic descending;
    logic last_row;

    logic p1_valid_reg;
    logic p1_adv;
    row_t p1_row_reg;
    col_t p1_final_reg;
    logic p1_last_reg;
    col_t rd_data_reg;

    logic ov_reg;
    logic out_load_ok;
    row_t out_row_reg;
    col_t out_first_reg;
    col_t out_final_reg;
    logic out_last_reg;

    assign phase_after = next_phase(state_reg, head);

    // read pipe: address out, start column back, then output register
    assign out_load_ok = !ov_reg || m_axis_tready;
    assign p1_adv      = p1_valid_reg && out_load_ok;
    assign issue_ok    = !p1_valid_reg || p1_adv;

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        cnt_next   = cnt_reg;
        if (advance)
        begin
            state_next = phase_after;
            case (phase_after)
                BK_CLOSE_TOP:
                begin
                    row_next = head.ct_first;
                    cnt_next = head.ct_cnt;
                end
                BK_CLOSE_BOT:
                begin
                    row_next = head.cb_first;
                    cnt_next = head.cb_cnt;
                end
                BK_OPEN_TOP:
                begin
                    row_next = head.ot_first;
                    cnt_next = head.ot_cnt;
                end
                BK_OPEN_BOT:
                begin
                    row_next = head.ob_first;
                    cnt_next = head.ob_cnt;
                end
                default:
                begin
                    cnt_next = '0;
                end
            endcase
        end
        else if (step)
        begin
            row_next = descending ? row_reg - ROW_W'(1) : row_reg + ROW_W'(1);
            cnt_next = cnt_reg - CNT_ONE;
        end
    end

    always_comb
    begin
        issue      = 1'b0;
        wr_en      = 1'b0;
        descending = 1'b0;
        case (state_reg)
            BK_CLOSE_TOP:
            begin
                issue = issue_ok;
            end
            BK_CLOSE_BOT:
            begin
                issue      = issue_ok;
                descending = 1'b1;
            end
            BK_OPEN_TOP:
            begin
                wr_en = 1'b1;
            end
            BK_OPEN_BOT:
            begin
                wr_en      = 1'b1;
                descending = 1'b1;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
        step     = issue || wr_en;
        advance  = (state_reg == BK_IDLE) ? head_valid : (step && cnt_reg == CNT_ONE);
        pop      = advance && (phase_after == BK_IDLE);
        last_row = (cnt_reg == CNT_ONE)
                   && ((state_reg == BK_CLOSE_BOT) || (head.cb_cnt == '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            row_reg      <= '0;
            cnt_reg      <= '0;
            p1_valid_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            cnt_reg   <= cnt_next;
            if (issue)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_adv)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[row_reg[IDX_W-1:0]] <= head.col;
        end
        if (issue)
        begin
            rd_data_reg  <= mem[row_reg[IDX_W-1:0]];
            p1_row_reg   <= row_reg;
            p1_final_reg <= head.final_col;
            p1_last_reg  <= last_row;
        end
        if (p1_adv)
        begin
            out_row_reg   <= p1_row_reg;
            out_first_reg <= rd_data_reg;
            out_final_reg <= p1_final_reg;
            out_last_reg  <= p1_last_reg;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_final_reg, out_first_reg, out_row_reg};

    a_busy_has_rows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != BK_IDLE |-> cnt_reg != '0)
        else $error("busy phase with no rows left");

    a_no_issue_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg && ov_reg && !m_axis_tready |-> !issue)
        else $error("read issued into a full pipe");

    a_pop_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == BK_IDLE)
        else $error("command popped while phase still running");

endmodule

@@ design/column_to_row_span_converter.sv @@
// Column-to-row span converter.
// Input stream: one transaction per screen column with the row ranges of the
// previous and current column. Output stream: one transaction per finished
// horizontal span (row, start column, end column); tlast marks the last span
// of a column. Finished top rows come out ascending, then bottom rows
// descending. A column that finishes nothing gives no output transaction.
// cfg_we/cfg_wdata load view_rows (reset 64); write it only while idle. A
// column's first span passes the front-end register, command queue, phase
// state, RAM read and output register. The span engine makes one start-column
// RAM access a cycle per row touched (closed or opened) while not stalled.
// The front end takes a column every cycle until the 4-entry command queue
// fills. Reset empties the pipe and queue; the start-column RAM is not
// cleared. When the receiver stalls, the output register and one read in
// flight hold, span reads pause, and the queue backs up to the input.
module column_to_row_span_converter
    import crsc_pkg::*;
#(
    parameter int ROWS    = ROWS_DEF,
    parameter int COLUMNS = COLUMNS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [VR_W-1:0]       cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // column, prev_valid, prev_top, prev_bottom, cur_valid, cur_top, cur_bottom
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // span_row, span_first, span_final
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    logic [VR_W-1:0] view_rows_reg;
    logic            cmd_valid;
    logic            cmd_ready;
    span_cmd_t       cmd;
    logic            head_valid;
    logic            pop;
    span_cmd_t       head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_rows_reg <= VIEW_ROWS_RESET;
        end
        else if (cfg_we)
        begin
            view_rows_reg <= cfg_wdata;
        end
    end

    crsc_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .view_rows     (view_rows_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    crsc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cmd_valid),
        .push_ready (cmd_ready),
        .push_data  (cmd),
        .head_valid (head_valid),
        .pop        (pop),
        .head       (head)
    );

    crsc_back #(
        .ROWS (ROWS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ test/testbench.sv @@
module testbench
    import crsc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ROWS        = ROWS_DEF;
    localparam int OFF_ROW_TOP     = 32767;
    localparam int ITEMS_PER_PHASE = 46;
    localparam int NUM_PHASES      = 8;
    localparam int DRAIN_CYCLES    = 700;
    localparam int SETTLE_CYCLES   = 200;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_REPORTS     = 10;
    localparam int IDLE_PCT        = 9;
    localparam int N_DIRECTED      = 18;

    // view_rows per random phase: 0 acts as 1, 127 and 100 act as 64
    localparam int VIEW_ROWS_PHASES [NUM_PHASES] = '{64, 1, 0, 127, 33, 64, 100, 17};
    localparam int QUIET_PHASE = 5;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic               prev_valid;
        logic [RANGE_W-1:0] prev_top;
        logic [RANGE_W-1:0] prev_bottom;
        logic               cur_valid;
        logic [RANGE_W-1:0] cur_top;
        logic [RANGE_W-1:0] cur_bottom;
    } column_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] first_col;
        logic [COL_W-1:0] final_col;
        logic             end_of_column;
    } span_t;

    // n_spans < 0: expectation comes from the predictor
    typedef struct {
        int column;
        int pv;
        int pt;
        int pb;
        int cv;
        int ct;
        int cb;
        int n_spans;
        int row;
        int first_col;
        int final_col;
    } directed_t;

    directed_t directed_rows [N_DIRECTED] = '{
        // open every row at column 5; this also writes every start entry
        '{5,    0, 1023, 1023, 1, 0,    1023, 0, 0,  0,    0},
        '{6,    1, 0,    63,   1, 1,    63,   1, 0,  5,    5},
        '{7,    1, 1,    63,   1, 1,    62,   1, 63, 5,    6},
        // column zero: end column wraps
        '{0,    1, 1,    62,   0, 0,    0,    -1, 0, 0,    0},
        '{2047, 0, 0,    0,    1, 0,    1023, 0, 0,  0,    0},
        '{0,    1, 0,    1023, 1, 10,   20,   -1, 0, 0,    0},
        '{100,  1, 10,   20,   1, 30,   40,   -1, 0, 0,    0},
        // empty ranges on both sides
        '{200,  1, 40,   30,   1, 50,   45,   0, 0,  0,    0},
        // invalid ranges with all-ones fields
        '{201,  0, 1023, 1023, 0, 1023, 1023, 0, 0,  0,    0},
        '{1,    1, 30,   40,   1, 30,   40,   0, 0,  0,    0},
        '{2,    1, 30,   40,   1, 35,   45,   -1, 0, 0,    0},
        '{3,    1, 35,   45,   1, 0,    1023, 0, 0,  0,    0},
        // every row closes at once
        '{4,    1, 0,    1023, 0, 0,    0,    -1, 0, 0,    0},
        '{8,    0, 0,    0,    1, 0,    63,   0, 0,  0,    0},
        '{9,    1, 0,    63,   1, 0,    0,    -1, 0, 0,    0},
        '{10,   1, 0,    0,    1, 1023, 1023, 1, 0,  8,    9},
        '{2047, 0, 0,    0,    1, 0,    63,   0, 0,  0,    0},
        '{1500, 1, 0,    63,   1, 1,    63,   1, 0,  2047, 1499}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [VR_W-1:0]       cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    bit              idle_on = 1'b1;
    logic [VR_W-1:0] view_rows_cfg = VIEW_ROWS_RESET;
    logic [COL_W-1:0] start_col [NUM_ROWS];
    span_t           expected_spans [$];
    span_t           found_spans [NUM_ROWS];
    int              found_n;
    int              mismatches = 0;
    int              cycle_count = 0;

    // random run state: the previous column's range
    logic             chain_valid;
    int               chain_top;
    int               chain_bottom;
    logic [COL_W-1:0] chain_col;

    column_to_row_span_converter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int visible_rows();
        int v;
        v = int'(view_rows_cfg);
        if (v < 1) v = 1;
        if (v > NUM_ROWS) v = NUM_ROWS;
        return v;
    endfunction

    function automatic span_t make_span(input int row, input logic [COL_W-1:0] end_col);
        return '{ROW_W'(row), start_col[row % NUM_ROWS], end_col, 1'b0};
    endfunction

    // fills found_spans with the spans a column finishes and updates the start table
    function automatic void predict_spans(input column_t c);
        int vr, t1, b1, t2, b2, lim;
        logic [COL_W-1:0] end_col;
        vr = visible_rows();
        end_col = c.column - COL_W'(1);
        found_n = 0;
        if (c.prev_valid)
        begin
            t1 = int'(c.prev_top);
            b1 = int'(c.prev_bottom);
        end
        else
        begin
            t1 = OFF_ROW_TOP;
            b1 = -1;
        end
        if (c.cur_valid)
        begin
            t2 = int'(c.cur_top);
            b2 = int'(c.cur_bottom);
        end
        else
        begin
            t2 = OFF_ROW_TOP;
            b2 = -1;
        end
        if (b1 > vr - 1) b1 = vr - 1;
        if (b2 > vr - 1) b2 = vr - 1;

        lim = (t2 < b1 + 1) ? t2 : b1 + 1;
        while (t1 < lim && found_n < NUM_ROWS)
        begin
            found_spans[found_n] = make_span(t1, end_col);
            found_n++;
            t1++;
        end
        lim = (b2 > t1 - 1) ? b2 : t1 - 1;
        while (b1 > lim && found_n < NUM_ROWS)
        begin
            found_spans[found_n] = make_span(b1, end_col);
            found_n++;
            b1--;
        end

        lim = (t1 < b2 + 1) ? t1 : b2 + 1;
        while (t2 < lim)
        begin
            start_col[t2 % NUM_ROWS] = c.column;
            t2++;
        end
        lim = (b1 > t2 - 1) ? b1 : t2 - 1;
        if (lim < -1) lim = -1;
        while (b2 > lim)
        begin
            start_col[b2 % NUM_ROWS] = c.column;
            b2--;
        end

        if (found_n > 0) found_spans[found_n - 1].end_of_column = 1'b1;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_column(input column_t c);
        return IN_DATA_W'({c.cur_bottom, c.cur_top, c.cur_valid,
                           c.prev_bottom, c.prev_top, c.prev_valid, c.column});
    endfunction

    function automatic int jitter(input int base, input int vr);
        int v;
        if (base > vr + 3)
            v = int'($urandom_range(vr - 1, 0));
        else
            v = base + int'($urandom_range(6, 0)) - 3;
        if (v < 0) v = 0;
        return v;
    endfunction

    // mostly a continuing run of columns, the rest noise
    function automatic column_t next_column();
        column_t c;
        int vr, pick, top, bottom;
        vr = visible_rows();
        pick = int'($urandom_range(99, 0));
        if (pick < 20)
        begin
            c = $bits(column_t)'({$urandom(), $urandom()});
        end
        else
        begin
            chain_col = chain_col + COL_W'(1);
            c.column = chain_col;
            c.prev_valid = chain_valid;
            c.prev_top = RANGE_W'(chain_top);
            c.prev_bottom = RANGE_W'(chain_bottom);
            if (pick < 28)
            begin
                c.cur_valid = 1'b0;
                c.cur_top = RANGE_W'($urandom());
                c.cur_bottom = RANGE_W'($urandom());
            end
            else if (pick < 36)
            begin
                c.cur_valid = 1'b1;
                c.cur_top = RANGE_W'($urandom_range(vr, 0));
                c.cur_bottom = RANGE_W'($urandom());
            end
            else
            begin
                c.cur_valid = 1'b1;
                top = chain_valid ? jitter(chain_top, vr) : int'($urandom_range(vr - 1, 0));
                bottom = chain_valid ? jitter(chain_bottom, vr) :
                                       top + int'($urandom_range(vr, 0));
                c.cur_top = RANGE_W'(top);
                c.cur_bottom = RANGE_W'(bottom);
            end
        end
        chain_valid = c.cur_valid;
        chain_top = int'(c.cur_top);
        chain_bottom = int'(c.cur_bottom);
        return c;
    endfunction

    task automatic send_column(input column_t c, input int typed_n, input span_t typed_span);
        while (idle_on && $urandom_range(99, 0) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pack_column(c);
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_spans(c);
        if (typed_n >= 0)
        begin
            if (typed_n > 0) expected_spans.push_back(typed_span);
        end
        else
        begin
            for (int k = 0; k < found_n; k++) expected_spans.push_back(found_spans[k]);
        end
    endtask

    // block must be idle: drain all spans, then let silent columns finish
    task automatic write_view_rows(input logic [VR_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (expected_spans.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        view_rows_cfg = value;
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= !(idle_on && ($urandom_range(99, 0) < IDLE_PCT));
    end

    always @(posedge clk)
    begin : span_monitor
        span_t got;
        span_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tdata[ROW_W-1:0],
                    m_axis_tdata[ROW_W+COL_W-1:ROW_W],
                    m_axis_tdata[ROW_W+2*COL_W-1:ROW_W+COL_W],
                    m_axis_tlast};
            if (expected_spans.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected span: row %0d first %0d final %0d last %0b",
                             got.row, got.first_col, got.final_col, got.end_of_column);
            end
            else
            begin
                want = expected_spans.pop_front();
                if (got.row != want.row || got.first_col != want.first_col ||
                    got.final_col != want.final_col ||
                    got.end_of_column != want.end_of_column)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("span mismatch: expected row %0d first %0d final %0d last %0b, got row %0d first %0d final %0d last %0b",
                                 want.row, want.first_col, want.final_col, want.end_of_column,
                                 got.row, got.first_col, got.final_col, got.end_of_column);
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        column_t c;
        span_t   typed;
        typed = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        write_view_rows(VR_W'(64));

        foreach (directed_rows[i])
        begin
            c.column = COL_W'(directed_rows[i].column);
            c.prev_valid = directed_rows[i].pv != 0;
            c.prev_top = RANGE_W'(directed_rows[i].pt);
            c.prev_bottom = RANGE_W'(directed_rows[i].pb);
            c.cur_valid = directed_rows[i].cv != 0;
            c.cur_top = RANGE_W'(directed_rows[i].ct);
            c.cur_bottom = RANGE_W'(directed_rows[i].cb);
            typed = '{ROW_W'(directed_rows[i].row), COL_W'(directed_rows[i].first_col),
                      COL_W'(directed_rows[i].final_col), 1'b1};
            send_column(c, directed_rows[i].n_spans, typed);
        end

        chain_valid = 1'b1;
        chain_top = 1;
        chain_bottom = 63;
        chain_col = COL_W'(1500);
        typed = '0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_view_rows(VR_W'(VIEW_ROWS_PHASES[p]));
            idle_on = (p != QUIET_PHASE);
            repeat (ITEMS_PER_PHASE) send_column(next_column(), -1, typed);
        end

        s_axis_tvalid <= 1'b0;
        while (expected_spans.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
